FILE: rtl/atbu_pkg.sv
// Shared types, codes and helpers for the ARM/THUMB branch unit.
package atbu_pkg;

    localparam int unsigned XLEN = 32;

    localparam logic [XLEN-1:0] LINK_OFS_ARM   = 32'hFFFF_FFFC;
    localparam logic [XLEN-1:0] LINK_OFS_THUMB = 32'hFFFF_FFFF;

    localparam logic [1:0] COST_TAKEN = 2'd3;
    localparam logic [1:0] COST_PLAIN = 2'd1;

    typedef enum logic [3:0] {
        FN_BX      = 4'd0,
        FN_BLXREG  = 4'd1,
        FN_B       = 4'd2,
        FN_BL      = 4'd3,
        FN_BLXIMM  = 4'd4,
        FN_TBX     = 4'd5,
        FN_TBLXREG = 4'd6,
        FN_TBCOND  = 4'd7,
        FN_TB      = 4'd8,
        FN_TBLHI   = 4'd9,
        FN_TBLLO   = 4'd10,
        FN_TBLXLO  = 4'd11
    } t_func;

    typedef enum logic [3:0] {
        CC_EQ = 4'd0,
        CC_NE = 4'd1,
        CC_CS = 4'd2,
        CC_CC = 4'd3,
        CC_MI = 4'd4,
        CC_PL = 4'd5,
        CC_VS = 4'd6,
        CC_VC = 4'd7,
        CC_HI = 4'd8,
        CC_LS = 4'd9,
        CC_GE = 4'd10,
        CC_LT = 4'd11,
        CC_GT = 4'd12,
        CC_LE = 4'd13,
        CC_AL = 4'd14,
        CC_NV = 4'd15
    } t_cond;

    typedef struct packed {
        logic [XLEN-1:0] tgt_a;
        logic [XLEN-1:0] tgt_b;
        logic [XLEN-1:0] link_a;
        logic [XLEN-1:0] link_b;
        logic            pcw;
        logic            lw;
        logic            tout;
    } t_dec;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic            pcw;
        logic [XLEN-1:0] link_value;
        logic            lw;
        logic            tout;
    } t_exec;

    function automatic logic cond_pass(input t_cond c, input logic [3:0] f);
        logic n;
        logic z;
        logic cy;
        logic v;
        logic res;
        n  = f[3];
        z  = f[2];
        cy = f[1];
        v  = f[0];
        unique case (c)
            CC_EQ: res = z;
            CC_NE: res = !z;
            CC_CS: res = cy;
            CC_CC: res = !cy;
            CC_MI: res = n;
            CC_PL: res = !n;
            CC_VS: res = v;
            CC_VC: res = !v;
            CC_HI: res = cy && !z;
            CC_LS: res = !cy || z;
            CC_GE: res = (n == v);
            CC_LT: res = (n != v);
            CC_GT: res = !z && (n == v);
            CC_LE: res = z || (n != v);
            CC_AL: res = 1'b0;
            CC_NV: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/atbu_decode.sv
// Decode stage: operand selection, offset extraction and condition test.
module atbu_decode import atbu_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_func           i_func,
    input  logic [XLEN-1:0] i_opcode,
    input  logic [XLEN-1:0] i_pc_now,
    input  logic [XLEN-1:0] i_link_now,
    input  logic [XLEN-1:0] i_reg_value,
    input  logic [3:0]      i_flags_nzcv,
    input  logic            i_thumb_in,
    output logic            o_valid,
    input  logic            i_ready,
    output t_dec            o_dec
);

    logic r_valid;
    t_dec r_dec;
    t_dec n_dec;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    always_comb begin
        n_dec        = '0;
        n_dec.tgt_a  = i_pc_now;
        n_dec.link_a = i_pc_now;
        n_dec.tout   = i_thumb_in;
        unique case (i_func)
            FN_BX, FN_BLXREG, FN_TBX, FN_TBLXREG: begin
                n_dec.tgt_a = i_reg_value;
                n_dec.pcw   = 1'b1;
                n_dec.tout  = i_reg_value[0];
                if (i_func == FN_BLXREG) begin
                    n_dec.link_b = LINK_OFS_ARM;
                    n_dec.lw     = 1'b1;
                end
                if (i_func == FN_TBLXREG) begin
                    n_dec.link_b = LINK_OFS_THUMB;
                    n_dec.lw     = 1'b1;
                end
            end
            FN_B, FN_BL, FN_BLXIMM: begin
                n_dec.tgt_b = {{6{i_opcode[23]}}, i_opcode[23:0], 2'b00};
                n_dec.pcw   = 1'b1;
                if (i_func == FN_BLXIMM) begin
                    n_dec.tgt_b[1] = i_opcode[24];
                    n_dec.tout     = 1'b1;
                end
                if (i_func != FN_B) begin
                    n_dec.link_b = LINK_OFS_ARM;
                    n_dec.lw     = 1'b1;
                end
            end
            FN_TBCOND: begin
                n_dec.tgt_b = {{23{i_opcode[7]}}, i_opcode[7:0], 1'b0};
                n_dec.pcw   = cond_pass(t_cond'(i_opcode[11:8]), i_flags_nzcv);
            end
            FN_TB: begin
                n_dec.tgt_b = {{20{i_opcode[10]}}, i_opcode[10:0], 1'b0};
                n_dec.pcw   = 1'b1;
            end
            FN_TBLHI: begin
                n_dec.link_b = {{9{i_opcode[10]}}, i_opcode[10:0], 12'h000};
                n_dec.lw     = 1'b1;
            end
            FN_TBLLO, FN_TBLXLO: begin
                n_dec.tgt_a  = i_link_now;
                n_dec.tgt_b  = {20'h00000, i_opcode[10:0], 1'b0};
                n_dec.pcw    = 1'b1;
                n_dec.link_b = LINK_OFS_THUMB;
                n_dec.lw     = 1'b1;
                if (i_func == FN_TBLXLO) begin
                    n_dec.tout = 1'b0;
                end
            end
            default: begin
                n_dec = n_dec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

endmodule

FILE: rtl/atbu_adder.sv
// Add stage: target and link adders with masking of unwritten values.
module atbu_adder import atbu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_dec  i_dec,
    output logic  o_valid,
    input  logic  i_ready,
    output t_exec o_exec
);

    logic  r_valid;
    t_exec r_exec;
    t_exec n_exec;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_exec  = r_exec;

    always_comb begin
        n_exec.next_pc    = i_dec.pcw ? (i_dec.tgt_a + i_dec.tgt_b) : '0;
        n_exec.pcw        = i_dec.pcw;
        n_exec.link_value = i_dec.lw ? (i_dec.link_a + i_dec.link_b) : '0;
        n_exec.lw         = i_dec.lw;
        n_exec.tout       = i_dec.tout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_exec <= n_exec;
        end
    end

endmodule

FILE: rtl/arm_thumb_branch_unit.sv
// Top level of the ARM/THUMB branch unit: stage chain and output register.
//
// Usage: one branch request per slave-side transfer (s_tvalid/s_tready).
// s_tuser carries the branch kind; s_tdata carries opcode, prefetched PC,
// current link register, source register value, NZCV flags and the THUMB
// bit. Each request yields exactly one result on the master side
// (m_tvalid/m_tready): next PC, PC write enable, link value, link write
// enable, new THUMB bit and the cycle cost (3 taken, 1 otherwise).
// A request passes the decode, adder and output registers before m_tvalid.
// Throughput is one request per cycle while m_tready does not stall; the
// two 32-bit adders in the middle stage set the cycle time.
// Synchronous active-low reset empties all stages; payload is not cleared.
// When the receiver stalls, each stage holds its request and a stage only
// refuses new input while it is full and the stage after it is blocked,
// so nothing is dropped or repeated and up to three requests stay buffered.
module arm_thumb_branch_unit import atbu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[31:0], pc_now[63:32], link_now[95:64], reg_value[127:96],
    // flags_nzcv[131:128], thumb_in[132], zero pad[135:133]
    input  logic [135:0] s_tdata,
    // func[3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[31:0], pc_written[32], link_value[64:33], link_written[65],
    // thumb_out[66], cycle_cost[68:67], zero pad[71:69]
    output logic [71:0]  m_tdata
);

    logic        dec_valid;
    logic        dec_ready;
    t_dec        dec;
    logic        exe_valid;
    logic        exe_ready;
    t_exec       exe;
    logic        r_m_valid;
    logic [71:0] r_m_data;
    logic [71:0] n_m_data;

    atbu_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_func       (t_func'(s_tuser)),
        .i_opcode     (s_tdata[31:0]),
        .i_pc_now     (s_tdata[63:32]),
        .i_link_now   (s_tdata[95:64]),
        .i_reg_value  (s_tdata[127:96]),
        .i_flags_nzcv (s_tdata[131:128]),
        .i_thumb_in   (s_tdata[132]),
        .o_valid      (dec_valid),
        .i_ready      (dec_ready),
        .o_dec        (dec)
    );

    atbu_adder u_adder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec),
        .o_valid (exe_valid),
        .i_ready (exe_ready),
        .o_exec  (exe)
    );

    assign exe_ready = !r_m_valid || m_tready;
    assign m_tvalid  = r_m_valid;
    assign m_tdata   = r_m_data;

    always_comb begin
        n_m_data = {3'b000, (exe.pcw ? COST_TAKEN : COST_PLAIN), exe.tout, exe.lw,
                    exe.link_value, exe.pcw, exe.next_pc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (exe_ready) begin
            r_m_valid <= exe_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exe_ready && exe_valid) begin
            r_m_data <= n_m_data;
        end
    end

endmodule
